@@ rtl/precedence_expression_evaluator_unit_macros.svh @@
// Assertion helpers used by the evaluator top level.
`ifndef PRECEDENCE_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH
`define PRECEDENCE_EXPRESSION_EVALUATOR_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PEE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/pee_pkg.sv @@
package pee_pkg;

   // Operator codes carried with each operand.
   localparam logic [2:0] OPC_ADD = 3'd0;
   localparam logic [2:0] OPC_SUB = 3'd1;
   localparam logic [2:0] OPC_MUL = 3'd2;
   localparam logic [2:0] OPC_DIV = 3'd3;
   localparam logic [2:0] OPC_END = 3'd4;

   // Pending multiplicative operator codes.
   localparam logic [1:0] PEND_NONE = 2'd0;
   localparam logic [1:0] PEND_MUL  = 2'd1;
   localparam logic [1:0] PEND_DIV  = 2'd2;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_TERM,
      ST_SUM,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load;
      logic       mul_en;
      logic       acc_en;
      logic [1:0] mul_idx;
      logic       div_en;
      logic       term_en;
      logic       sum_en;
      logic       emit_en;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] pend_op;
      logic [2:0] op;
      logic       divisor_zero;
   } status_type;

endpackage

@@ rtl/precedence_expression_evaluator_unit.sv @@
// Channel  Direction  Handshake          Payload
// req      in         req_valid/stall    operand_value, operation
// rsp      out        rsp_valid/stall    result_value, divide_by_zero, overflowed
//
// A beat is accepted only in the idle state, so each beat is worked off before the next is
// taken: a pending multiply or divide adds its steps, a zero divisor skips the divide steps,
// a multiply or divide beat skips the sum step, and an end beat adds the emit step.
// Reset is synchronous; it clears the expression state and the output valid.
// A stalled result stays in the output register while the next beat is taken;
// only a beat that ends the expression (end or spare code) waits for that register to drain.
`include "precedence_expression_evaluator_unit_macros.svh"

module precedence_expression_evaluator_unit #(
   parameter int FRAC_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [63:0] req_operand_value,
   input  logic [2:0]         req_operation,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_result_value,
   output logic               rsp_divide_by_zero,
   output logic               rsp_overflowed
);

   pee_pkg::cmd_type    cmd;
   pee_pkg::status_type status;
   logic                req_take;
   logic                other_work;
   logic                out_free;

   // Sequencer.
   pee_ctrl #(
      .FRAC_BITS (FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and expression state.
   pee_dpath #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_operand_value  (req_operand_value),
      .req_operation      (req_operation),
      .rsp_result_value   (rsp_result_value),
      .rsp_divide_by_zero (rsp_divide_by_zero),
      .rsp_overflowed     (rsp_overflowed)
   );

   // Conditions watched by the assertions.
   assign req_take   = req_valid && !req_stall;
   assign other_work = cmd.term_en || cmd.sum_en || cmd.emit_en || cmd.div_en;
   assign out_free   = !rsp_valid || !rsp_stall;

   // An accepted beat keeps the input side busy in the next cycle.
   `PEE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_take, req_stall, "no stall after accept")

   // A new beat never loads while the datapath is finishing a term.
   `PEE_ASSERT_SAME(a_load_exclusive, clock, reset, cmd.load, !other_work, "load overlaps work")

   // A result only enters a free output register.
   `PEE_ASSERT_SAME(a_emit_free, clock, reset, cmd.emit_en, out_free, "held beat overwritten")

   // An emitted result is presented in the next cycle.
   `PEE_ASSERT_NEXT(a_emit_valid, clock, reset, cmd.emit_en, rsp_valid, "result not valid")

endmodule

@@ rtl/pee_ctrl.sv @@
module pee_ctrl #(
   parameter int FRAC_BITS = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  pee_pkg::status_type status,
   output pee_pkg::cmd_type    cmd
);

   localparam int DivSteps = 64 + FRAC_BITS;
   localparam int CntW     = $clog2(DivSteps);
   localparam int MulSteps = 4;

   pee_pkg::state_type state_ff, state_in;
   logic [CntW-1:0]    cnt_ff, cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // State, step counter and output valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pee_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.mul_idx = cnt_ff[1:0];
      unique case (state_ff)
         pee_pkg::ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.pend_op == pee_pkg::PEND_MUL) begin
                  state_in = pee_pkg::ST_MUL;
               end else if (status.pend_op == pee_pkg::PEND_DIV) begin
                  state_in = pee_pkg::ST_DIV;
               end else begin
                  state_in = pee_pkg::ST_TERM;
               end
            end
         end
         pee_pkg::ST_MUL: begin
            // Four partial products, each registered and accumulated in the cycle after it is formed.
            cmd.mul_en = (cnt_ff < CntW'(MulSteps));
            cmd.acc_en = (cnt_ff != '0);
            cnt_in     = cnt_ff + 1'b1;
            if (cnt_ff == CntW'(MulSteps)) begin
               cnt_in   = '0;
               state_in = pee_pkg::ST_TERM;
            end
         end
         pee_pkg::ST_DIV: begin
            // One quotient bit per cycle; a zero divisor skips the iterations.
            if (status.divisor_zero) begin
               state_in = pee_pkg::ST_TERM;
            end else begin
               cmd.div_en = 1'b1;
               cnt_in     = cnt_ff + 1'b1;
               if (cnt_ff == CntW'(DivSteps - 1)) begin
                  cnt_in   = '0;
                  state_in = pee_pkg::ST_TERM;
               end
            end
         end
         pee_pkg::ST_TERM: begin
            cmd.term_en = 1'b1;
            unique case (status.op) inside
               pee_pkg::OPC_MUL, pee_pkg::OPC_DIV: state_in = pee_pkg::ST_IDLE;
               default:                            state_in = pee_pkg::ST_SUM;
            endcase
         end
         pee_pkg::ST_SUM: begin
            cmd.sum_en = 1'b1;
            unique case (status.op) inside
               pee_pkg::OPC_ADD, pee_pkg::OPC_SUB: state_in = pee_pkg::ST_IDLE;
               pee_pkg::OPC_END:                   state_in = pee_pkg::ST_EMIT;
               default:                            state_in = pee_pkg::ST_EMIT;
            endcase
         end
         pee_pkg::ST_EMIT: begin
            // Wait until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.emit_en = 1'b1;
               state_in    = pee_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pee_pkg::ST_IDLE;
         end
      endcase
   end

   // The output register holds its beat until it is taken.
   assign rsp_valid_in = cmd.emit_en | (rsp_valid_ff & rsp_stall);

   assign req_stall = (state_ff != pee_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/pee_dpath.sv @@
module pee_dpath #(
   parameter int FRAC_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pee_pkg::cmd_type     cmd,
   output pee_pkg::status_type  status,
   input  logic signed [63:0]   req_operand_value,
   input  logic [2:0]           req_operation,
   output logic signed [63:0]   rsp_result_value,
   output logic                 rsp_divide_by_zero,
   output logic                 rsp_overflowed
);

   localparam int DivW = 64 + FRAC_BITS;
   localparam logic [63:0] PosMax = {1'b0, {63{1'b1}}};
   localparam logic [63:0] NegMin = {1'b1, {63{1'b0}}};

   // Expression state.
   logic [63:0]  sum_ff, sum_in;
   logic [63:0]  prod_ff, prod_in;
   logic [1:0]   pend_op_ff, pend_op_in;
   logic         pend_sign_ff, pend_sign_in;
   logic         dz_ff, dz_in;
   logic         ovf_ff, ovf_in;

   // Working registers for one item.
   logic [63:0]     opnd_ff, opnd_in;
   logic [2:0]      op_ff, op_in;
   logic [63:0]     mag_a_ff, mag_a_in;
   logic [63:0]     mag_b_ff, mag_b_in;
   logic            neg_ff, neg_in;
   logic [63:0]     pp_ff, pp_in;
   logic [1:0]      pp_idx_ff, pp_idx_in;
   logic [127:0]    acc_ff, acc_in;
   logic [63:0]     rem_ff, rem_in;
   logic [DivW-1:0] dq_ff, dq_in;
   logic [63:0]     term_ff, term_in;

   // Output register payload.
   logic [63:0] out_val_ff, out_val_in;
   logic        out_dz_ff, out_dz_in;
   logic        out_ovf_ff, out_ovf_in;

   logic [31:0]  a_half, b_half;
   logic [127:0] pp_shifted;
   logic [64:0]  rem_shift, rem_diff;
   logic         quo_bit;
   logic [64:0]  sat_res;
   logic [63:0]  term_val;
   logic         term_ovf, term_dz;
   logic [63:0]  add_val, sub_val, sum_val;
   logic         add_ovf, sub_ovf, sum_ovf;

   function automatic logic [63:0] magnitude(input logic [63:0] x);
      return x[63] ? (64'd0 - x) : x;
   endfunction

   // Applies a sign to a magnitude with saturation; the top bit flags overflow.
   function automatic logic [64:0] apply_sign(input logic neg, input logic [63:0] mag,
                                               input logic big);
      logic [64:0] res;
      if (!neg) begin
         res = (big || mag[63]) ? {1'b1, PosMax} : {1'b0, mag};
      end else begin
         res = (big || (mag[63] && (|mag[62:0]))) ? {1'b1, NegMin}
                                                  : {1'b0, 64'd0 - mag};
      end
      return res;
   endfunction

   // Partial product operands and their weight.
   assign a_half = cmd.mul_idx[1] ? mag_a_ff[63:32] : mag_a_ff[31:0];
   assign b_half = cmd.mul_idx[0] ? mag_b_ff[63:32] : mag_b_ff[31:0];
   always_comb begin
      case (pp_idx_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd3:    pp_shifted = {pp_ff, 64'd0};
         default: pp_shifted = {32'd0, pp_ff, 32'd0};
      endcase
   end

   // Restoring divide step.
   assign rem_shift = {rem_ff, dq_ff[DivW-1]};
   assign rem_diff  = rem_shift - {1'b0, mag_b_ff};
   assign quo_bit   = ~rem_diff[64];

   // Term value from the pending operator.
   always_comb begin
      term_val = opnd_ff;
      term_ovf = 1'b0;
      term_dz  = 1'b0;
      sat_res  = '0;
      case (pend_op_ff)
         pee_pkg::PEND_MUL: begin
            sat_res  = apply_sign(neg_ff, acc_ff[FRAC_BITS +: 64],
                                  |acc_ff[127:FRAC_BITS+64]);
            term_val = sat_res[63:0];
            term_ovf = sat_res[64];
         end
         pee_pkg::PEND_DIV: begin
            if (mag_b_ff == 64'd0) begin
               term_dz = 1'b1;
               if (prod_ff == 64'd0) begin
                  term_val = 64'd0;
               end else begin
                  term_val = prod_ff[63] ? NegMin : PosMax;
               end
            end else begin
               sat_res  = apply_sign(neg_ff, dq_ff[63:0], |dq_ff[DivW-1:64]);
               term_val = sat_res[63:0];
               term_ovf = sat_res[64];
            end
         end
         default: begin
            term_val = opnd_ff;
         end
      endcase
   end

   // Saturating add and subtract into the running sum.
   assign add_val = sum_ff + term_ff;
   assign sub_val = sum_ff - term_ff;
   assign add_ovf = ~(sum_ff[63] ^ term_ff[63]) & (add_val[63] ^ sum_ff[63]);
   assign sub_ovf = (sum_ff[63] ^ term_ff[63]) & (sub_val[63] ^ sum_ff[63]);
   always_comb begin
      sum_ovf = pend_sign_ff ? sub_ovf : add_ovf;
      if (sum_ovf) begin
         sum_val = sum_ff[63] ? NegMin : PosMax;
      end else begin
         sum_val = pend_sign_ff ? sub_val : add_val;
      end
   end

   // Next values of all registers.
   always_comb begin
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      pend_op_in   = pend_op_ff;
      pend_sign_in = pend_sign_ff;
      dz_in        = dz_ff;
      ovf_in       = ovf_ff;
      opnd_in      = opnd_ff;
      op_in        = op_ff;
      mag_a_in     = mag_a_ff;
      mag_b_in     = mag_b_ff;
      neg_in       = neg_ff;
      pp_in        = pp_ff;
      pp_idx_in    = pp_idx_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dq_in        = dq_ff;
      term_in      = term_ff;
      out_val_in   = out_val_ff;
      out_dz_in    = out_dz_ff;
      out_ovf_in   = out_ovf_ff;

      // Capture a beat and prepare both arithmetic units.
      if (cmd.load) begin
         opnd_in  = req_operand_value;
         op_in    = req_operation;
         mag_a_in = magnitude(prod_ff);
         mag_b_in = magnitude(req_operand_value);
         neg_in   = prod_ff[63] ^ req_operand_value[63];
         acc_in   = '0;
         rem_in   = '0;
         dq_in    = {magnitude(prod_ff), {FRAC_BITS{1'b0}}};
      end

      if (cmd.mul_en) begin
         pp_in     = {32'd0, a_half} * {32'd0, b_half};
         pp_idx_in = cmd.mul_idx;
      end
      if (cmd.acc_en) begin
         acc_in = acc_ff + pp_shifted;
      end

      if (cmd.div_en) begin
         rem_in = quo_bit ? rem_diff[63:0] : rem_shift[63:0];
         dq_in  = {dq_ff[DivW-2:0], quo_bit};
      end

      // Finish the term; a multiplicative operator keeps it as the product chain.
      if (cmd.term_en) begin
         term_in = term_val;
         dz_in   = dz_ff | term_dz;
         ovf_in  = ovf_ff | term_ovf;
         if (op_ff == pee_pkg::OPC_MUL) begin
            prod_in    = term_val;
            pend_op_in = pee_pkg::PEND_MUL;
         end else if (op_ff == pee_pkg::OPC_DIV) begin
            prod_in    = term_val;
            pend_op_in = pee_pkg::PEND_DIV;
         end
      end

      if (cmd.sum_en) begin
         sum_in       = sum_val;
         ovf_in       = ovf_ff | sum_ovf;
         prod_in      = '0;
         pend_op_in   = pee_pkg::PEND_NONE;
         pend_sign_in = (op_ff == pee_pkg::OPC_SUB);
      end

      // Move the result to the output register and start a new expression.
      if (cmd.emit_en) begin
         out_val_in   = sum_ff;
         out_dz_in    = dz_ff;
         out_ovf_in   = ovf_ff;
         sum_in       = '0;
         prod_in      = '0;
         pend_op_in   = pee_pkg::PEND_NONE;
         pend_sign_in = 1'b0;
         dz_in        = 1'b0;
         ovf_in       = 1'b0;
      end
   end

   // Expression state has a defined reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= '0;
         prod_ff      <= '0;
         pend_op_ff   <= pee_pkg::PEND_NONE;
         pend_sign_ff <= 1'b0;
         dz_ff        <= 1'b0;
         ovf_ff       <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         prod_ff      <= prod_in;
         pend_op_ff   <= pend_op_in;
         pend_sign_ff <= pend_sign_in;
         dz_ff        <= dz_in;
         ovf_ff       <= ovf_in;
      end
   end

   // Working and output payload registers.
   always_ff @(posedge clock) begin
      opnd_ff    <= opnd_in;
      op_ff      <= op_in;
      mag_a_ff   <= mag_a_in;
      mag_b_ff   <= mag_b_in;
      neg_ff     <= neg_in;
      pp_ff      <= pp_in;
      pp_idx_ff  <= pp_idx_in;
      acc_ff     <= acc_in;
      rem_ff     <= rem_in;
      dq_ff      <= dq_in;
      term_ff    <= term_in;
      out_val_ff <= out_val_in;
      out_dz_ff  <= out_dz_in;
      out_ovf_ff <= out_ovf_in;
   end

   assign status.pend_op      = pend_op_ff;
   assign status.op           = op_ff;
   assign status.divisor_zero = (mag_b_ff == 64'd0);

   assign rsp_result_value   = out_val_ff;
   assign rsp_divide_by_zero = out_dz_ff;
   assign rsp_overflowed     = out_ovf_ff;

endmodule

@@ test/precedence_expression_evaluator_unit_checker.sv @@
`timescale 1ns / 100ps

// Watches both channels of the evaluator, predicts each result from the operand beats
// it accepts, and compares every accepted result beat with the oldest prediction.
module precedence_expression_evaluator_unit_checker #(
   parameter int FRAC_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [63:0] req_operand_value,
   input  logic [2:0]         req_operation,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [63:0] rsp_result_value,
   input  logic               rsp_divide_by_zero,
   input  logic               rsp_overflowed,
   output int                 mismatch_count,
   output int                 results_pending,
   output int                 beats_seen,
   output int                 results_seen,
   output int                 flagged_results
);

   localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
   localparam int          MAX_REPORTS = 10;

   typedef struct packed {
      logic [63:0] value;
      logic        div_zero;
      logic        overflow;
   } evaluation_type;

   // Predicted expression state.
   logic [63:0] running_total;
   logic [63:0] chain_value;
   logic [1:0]  chain_op;
   logic        subtract_next;
   logic        saw_zero_divisor;
   logic        saw_saturation;

   evaluation_type expected_results[$];
   int             mismatches;
   int             beats;
   int             results;
   int             flagged;

   function automatic void clear_expression();
      running_total    = '0;
      chain_value      = '0;
      chain_op         = pee_pkg::PEND_NONE;
      subtract_next    = 1'b0;
      saw_zero_divisor = 1'b0;
      saw_saturation   = 1'b0;
   endfunction

   function automatic logic [63:0] magnitude_of(logic [63:0] x);
      return x[63] ? 64'd0 - x : x;
   endfunction

   // Puts a sign on a magnitude, clamping to the fixed-point limits.
   function automatic logic [63:0] signed_limit(logic neg, logic [63:0] mag, logic big);
      if (!neg) begin
         if (big || mag > POS_LIMIT) begin
            saw_saturation = 1'b1;
            return POS_LIMIT;
         end
         return mag;
      end
      if (big || mag > NEG_LIMIT) begin
         saw_saturation = 1'b1;
         return NEG_LIMIT;
      end
      return 64'd0 - mag;
   endfunction

   // Advances the expression by one operand beat; returns 1 when a result is due.
   function automatic logic evaluate_beat(input logic [63:0] operand, input logic [2:0] opcode,
                                          output evaluation_type outcome);
      logic         neg;
      logic [127:0] wide;
      logic [63:0]  term;
      logic [63:0]  total;
      logic         wrapped;
      neg     = chain_value[63] ^ operand[63];
      outcome = '0;

      // Close the pending multiply or divide with this operand.
      case (chain_op)
         pee_pkg::PEND_MUL: begin
            wide = ({64'd0, magnitude_of(chain_value)} * {64'd0, magnitude_of(operand)})
                   >> FRAC_BITS;
            term = signed_limit(neg, wide[63:0], |wide[127:64]);
         end
         pee_pkg::PEND_DIV: begin
            if (operand == 64'd0) begin
               saw_zero_divisor = 1'b1;
               if (chain_value == 64'd0) term = 64'd0;
               else term = chain_value[63] ? NEG_LIMIT : POS_LIMIT;
            end else begin
               wide = ({64'd0, magnitude_of(chain_value)} << FRAC_BITS)
                      / {64'd0, magnitude_of(operand)};
               term = signed_limit(neg, wide[63:0], |wide[127:64]);
            end
         end
         default: term = operand;
      endcase

      if (opcode == pee_pkg::OPC_MUL || opcode == pee_pkg::OPC_DIV) begin
         chain_value = term;
         chain_op    = (opcode == pee_pkg::OPC_MUL) ? pee_pkg::PEND_MUL : pee_pkg::PEND_DIV;
         return 1'b0;
      end

      // The term is finished: fold it into the running sum with saturation.
      total = subtract_next ? running_total - term : running_total + term;
      wrapped = (subtract_next ? running_total[63] != term[63] : running_total[63] == term[63])
                && total[63] != running_total[63];
      if (wrapped) begin
         saw_saturation = 1'b1;
         total = running_total[63] ? NEG_LIMIT : POS_LIMIT;
      end
      running_total = total;
      chain_value   = '0;
      chain_op      = pee_pkg::PEND_NONE;

      if (opcode == pee_pkg::OPC_ADD || opcode == pee_pkg::OPC_SUB) begin
         subtract_next = (opcode == pee_pkg::OPC_SUB);
         return 1'b0;
      end

      // Any other code ends the expression.
      outcome.value    = total;
      outcome.div_zero = saw_zero_divisor;
      outcome.overflow = saw_saturation;
      clear_expression();
      return 1'b1;
   endfunction

   // Result beats are checked before operand beats of the same edge are predicted.
   always @(posedge clock) begin : watch
      evaluation_type outcome;
      evaluation_type want;
      if (reset) begin
         clear_expression();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results++;
            if (rsp_divide_by_zero || rsp_overflowed) flagged++;
            if (expected_results.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("ERROR: unexpected result beat value=%h dz=%b ovf=%b",
                           rsp_result_value, rsp_divide_by_zero, rsp_overflowed);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_value !== want.value || rsp_divide_by_zero !== want.div_zero ||
                   rsp_overflowed !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("ERROR: result %0d expected %h dz=%b ovf=%b, got %h dz=%b ovf=%b",
                              results, want.value, want.div_zero, want.overflow,
                              rsp_result_value, rsp_divide_by_zero, rsp_overflowed);
               end
            end
         end
         if (req_valid && !req_stall) begin
            beats++;
            if (evaluate_beat(req_operand_value, req_operation, outcome))
               expected_results.push_back(outcome);
         end
      end
      mismatch_count  <= mismatches;
      results_pending <= expected_results.size();
      beats_seen      <= beats;
      results_seen    <= results;
      flagged_results <= flagged;
   end

endmodule

@@ test/precedence_expression_evaluator_unit_test.sv @@
`timescale 1ns / 100ps

// Drives operand beats into the evaluator and gives the verdict from the checker's counts.
module precedence_expression_evaluator_unit_test;

   localparam int FRAC_BITS        = 32;
   localparam int RANDOM_BEATS     = 700;
   localparam int LONG_HOLD_CYCLES = 600;
   localparam int SETTLE_CYCLES    = 200;

   // Spare operator codes, which the block treats as end.
   localparam logic [2:0] OPC_SPARE_A = 3'd5;
   localparam logic [2:0] OPC_SPARE_B = 3'd6;
   localparam logic [2:0] OPC_SPARE_C = 3'd7;

   localparam logic signed [63:0] ONE           = 64'sd1 <<< FRAC_BITS;
   localparam logic signed [63:0] MOST_POSITIVE = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] MOST_NEGATIVE = 64'sh8000_0000_0000_0000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [63:0] req_operand_value;
   logic [2:0]         req_operation;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [63:0] rsp_result_value;
   logic               rsp_divide_by_zero;
   logic               rsp_overflowed;

   int mismatch_count;
   int results_pending;
   int beats_seen;
   int results_seen;
   int flagged_results;

   int   beats_sent = 0;
   int   holds_asked = 0;
   logic hold_active;
   bit   steady_sender = 1'b0;

   precedence_expression_evaluator_unit #(.FRAC_BITS(FRAC_BITS)) u_top (.*);

   precedence_expression_evaluator_unit_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard limit on the run, far beyond the slowest correct run.
   initial begin
      #50_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // Mostly no gap, sometimes a few cycles, rarely a long pause.
   function automatic int unsigned idle_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 20);
      return $urandom_range(40, 150);
   endfunction

   // Operands mix zero, the extremes, small numbers and wide random values.
   function automatic logic signed [63:0] pick_operand();
      int unsigned        roll;
      int                 whole;
      logic signed [63:0] full;
      roll  = $urandom_range(0, 99);
      whole = int'($urandom_range(0, 200)) - 100;
      full  = {$urandom, $urandom};
      if (roll < 12) return '0;
      if (roll < 22) begin
         case ($urandom_range(0, 5))
            0: return MOST_POSITIVE;
            1: return MOST_NEGATIVE;
            2: return -64'sd1;
            3: return 64'sd1;
            4: return ONE;
            default: return -ONE;
         endcase
      end
      if (roll < 40) return ONE * whole;
      if (roll < 60) return ONE * whole + ($urandom & (ONE - 1));
      if (roll < 80) return full >>> $urandom_range(8, 40);
      return full;
   endfunction

   // Offers one operand beat and waits until the block takes it.
   task automatic send_beat(input logic signed [63:0] operand, input logic [2:0] opcode);
      int unsigned gap;
      gap = steady_sender ? 0 : idle_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operand_value <= operand;
      req_operation     <= opcode;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   // Stops sending and waits until every predicted result has arrived.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
   endtask

   // One well-formed expression of random length and content.
   task automatic send_expression();
      int unsigned terms;
      steady_sender = ($urandom_range(0, 4) == 0);
      terms = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
      for (int unsigned i = 1; i < terms; i++)
         send_beat(pick_operand(),
                   3'($urandom_range(pee_pkg::OPC_ADD, pee_pkg::OPC_DIV)));
      send_beat(pick_operand(), ($urandom_range(0, 7) == 0) ?
                3'($urandom_range(OPC_SPARE_A, OPC_SPARE_C)) : pee_pkg::OPC_END);
   endtask

   // Result side: random stalls, quiet stretches, and one long hold when asked.
   initial begin : receiver
      int unsigned holds_given;
      holds_given = 0;
      hold_active <= 1'b0;
      forever begin
         if (holds_asked > holds_given) begin
            holds_given++;
            rsp_stall   <= 1'b1;
            hold_active <= 1'b1;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            hold_active <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat (($urandom_range(0, 3) == 0) ? $urandom_range(100, 400) :
                    $urandom_range(1, 20)) @(posedge clock);
            rsp_stall <= 1'b1;
            repeat (1 + idle_gap()) @(posedge clock);
         end
      end
   end

   initial begin : sender
      int expressions;
      expressions = 0;
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operand_value <= '0;
      req_operation     <= pee_pkg::OPC_ADD;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes, saturation on every operation, zero divisors, spare codes.
      send_beat(MOST_POSITIVE, pee_pkg::OPC_END);
      send_beat(MOST_NEGATIVE, OPC_SPARE_A);
      send_beat(MOST_POSITIVE, pee_pkg::OPC_ADD);
      send_beat(64'sd1, pee_pkg::OPC_END);
      send_beat(MOST_NEGATIVE, pee_pkg::OPC_SUB);
      send_beat(64'sd1, OPC_SPARE_B);
      send_beat(MOST_NEGATIVE, pee_pkg::OPC_MUL);
      send_beat(-ONE, pee_pkg::OPC_END);
      send_beat(2 * ONE, pee_pkg::OPC_MUL);
      send_beat(MOST_NEGATIVE, OPC_SPARE_C);
      send_beat(5 * ONE, pee_pkg::OPC_DIV);
      send_beat('0, pee_pkg::OPC_END);
      send_beat(-5 * ONE, pee_pkg::OPC_DIV);
      send_beat('0, pee_pkg::OPC_END);
      send_beat('0, pee_pkg::OPC_DIV);
      send_beat('0, pee_pkg::OPC_END);
      send_beat(ONE, pee_pkg::OPC_DIV);
      send_beat(64'sd1, pee_pkg::OPC_END);
      send_beat(7 * ONE, pee_pkg::OPC_SUB);
      send_beat(3 * ONE, pee_pkg::OPC_MUL);
      send_beat(2 * ONE, pee_pkg::OPC_ADD);
      send_beat(ONE, pee_pkg::OPC_DIV);
      send_beat(4 * ONE, pee_pkg::OPC_END);
      send_beat(-64'sd1, pee_pkg::OPC_MUL);
      send_beat(-64'sd1, pee_pkg::OPC_END);
      drain();

      // Random expressions, with pauses and one long result hold along the way.
      while (beats_sent < 25 + RANDOM_BEATS) begin
         send_expression();
         expressions++;
         if (expressions % 50 == 0) drain();
         if (expressions == 40) begin
            req_valid   <= 1'b0;
            holds_asked <= holds_asked + 1;
            @(posedge clock);
            while (!hold_active) @(posedge clock);
            repeat (5) send_expression();
         end
      end
      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Run covered %0d operand beats and %0d result beats, %0d of them flagged.",
               beats_seen, results_seen, flagged_results);
      if (mismatch_count == 0 && results_pending == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
